// ===== src/gfw_pkg.sv =====
// shared constants, types and helpers for the glyph frame buffer writer
// used by every module of the block; depends on nothing

package gfw_pkg;

  // frame buffer and font store geometry
  localparam int FB_COLS    = 320;
  localparam int FB_ROWS    = 240;
  localparam int FONT_BYTES = 4096;
  localparam int MAX_GLYPH  = 16;

  localparam int PIX_TOTAL = FB_COLS * FB_ROWS;
  localparam int FB_AW     = $clog2(PIX_TOTAL);
  localparam int FONT_AW   = $clog2(FONT_BYTES);

  // payload widths fixed by the interface
  localparam int PIX_W   = 16;
  localparam int FBYTE_W = 8;
  localparam int CODE_W  = 8;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int FADDR_W = 12;
  localparam int FUNC_W  = 3;
  localparam int SIZE_W  = 5;

  // glyph geometry
  localparam int GS_W       = $clog2(MAX_GLYPH + 1);
  localparam int GC_W       = $clog2(MAX_GLYPH);
  localparam int HDR_BYTES  = 4;
  localparam int FIRST_CODE = 32;
  localparam int RB_MAX     = (MAX_GLYPH + 7) / 8;
  localparam int RB_W       = $clog2(RB_MAX + 1);
  localparam int GB_MAX     = RB_MAX * MAX_GLYPH + HDR_BYTES;
  localparam int GB_W       = $clog2(GB_MAX + 1);
  localparam int FA_W       = $clog2(256 * GB_MAX);

  // text cursor
  localparam int CUR_W   = 11;
  localparam int CUR_MAX = (1 << CUR_W) - 1;

  // linear pixel index wide enough for any glyph pixel or sweep position
  localparam int PA_W = $clog2(PIX_TOTAL + MAX_GLYPH * FB_COLS + CUR_MAX + MAX_GLYPH + 1);

  // configuration port
  localparam int CFG_DW  = 32;
  localparam int PADDR_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_DRAW  = 3'd0,
    FN_SET   = 3'd1,
    FN_CLEAR = 3'd2,
    FN_FONT  = 3'd3,
    FN_READ  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    REG_FORE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [FB_AW-1:0] addr;
    logic [PIX_W-1:0] wdata;
  } frame_req_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [FONT_AW-1:0] addr;
    logic [FBYTE_W-1:0] wdata;
  } font_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]  fore;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } glyph_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
    logic             done;
  } result_t;

  // glyph size limited to the largest supported glyph
  function automatic logic [GS_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [GS_W-1:0] res;
    if (32'(v) > MAX_GLYPH) res = GS_W'(MAX_GLYPH);
    else                    res = GS_W'(v);
    return res;
  endfunction

endpackage

// ===== src/gfw_frame_mem.sv =====
// frame store: one synchronous pixel memory, one access per cycle
// depends on gfw_pkg for geometry and the request struct

module gfw_frame_mem (
  input  logic                    clk,
  input  gfw_pkg::frame_req_t     req,
  output logic [gfw_pkg::PIX_W-1:0] rdata
);
  import gfw_pkg::*;

  logic [PIX_W-1:0] mem [PIX_TOTAL];
  logic [PIX_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gfw_font_mem.sv =====
// font store: one synchronous byte memory, one access per cycle
// depends on gfw_pkg for geometry and the request struct

module gfw_font_mem (
  input  logic                        clk,
  input  gfw_pkg::font_req_t          req,
  output logic [gfw_pkg::FBYTE_W-1:0] rdata
);
  import gfw_pkg::*;

  logic [FBYTE_W-1:0] mem [FONT_BYTES];
  logic [FBYTE_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/gfw_engine.sv =====
// operation sequencer: glyph drawing, pixel set and read, clear sweep, font write
// depends on gfw_pkg; drives the frame and font memories through request structs

module gfw_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gfw_pkg::FUNC_W-1:0]    in_func,
  input  logic [gfw_pkg::CODE_W-1:0]    in_char_code,
  input  logic [gfw_pkg::X_W-1:0]       in_pos_x,
  input  logic [gfw_pkg::Y_W-1:0]       in_pos_y,
  input  logic [gfw_pkg::PIX_W-1:0]     in_pixel_color,
  input  logic [gfw_pkg::FADDR_W-1:0]   in_font_addr,
  input  logic [gfw_pkg::FBYTE_W-1:0]   in_font_byte,
  input  gfw_pkg::glyph_cfg_t           cfg,
  output gfw_pkg::frame_req_t           fr_req,
  input  logic [gfw_pkg::PIX_W-1:0]     fr_rdata,
  output gfw_pkg::font_req_t            fo_req,
  input  logic [gfw_pkg::FBYTE_W-1:0]   fo_rdata,
  output gfw_pkg::result_t              res,
  input  logic                          res_take
);
  import gfw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DSETUP,
    ST_DFETCH,
    ST_DPAINT,
    ST_DEND,
    ST_PMUL,
    ST_PWR,
    ST_PRD,
    ST_PRDW,
    ST_CLR,
    ST_FWR,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic               is_set_r, is_set_nxt;
  logic               in_range_r, in_range_nxt;
  logic [CODE_W-1:0]  idx_r, idx_nxt;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [Y_W-1:0]     y_r, y_nxt;
  logic [PIX_W-1:0]   color_r, color_nxt;
  logic [FONT_AW-1:0] fwa_r, fwa_nxt;
  logic [FBYTE_W-1:0] fwb_r, fwb_nxt;
  logic [GS_W-1:0]    w_r, w_nxt;
  logic [GS_W-1:0]    h_r, h_nxt;
  logic [GB_W-1:0]    gbytes_r, gbytes_nxt;
  logic [FA_W-1:0]    fa_r, fa_nxt;
  logic               oob_r, oob_nxt;
  logic [GC_W-1:0]    c_r, c_nxt;
  logic [GC_W-1:0]    row_r, row_nxt;
  logic [PA_W-1:0]    row_base_r, row_base_nxt;
  logic [PA_W-1:0]    ymul_r, ymul_nxt;
  logic [FB_AW-1:0]   sweep_r, sweep_nxt;
  logic [CUR_W-1:0]   cursor_r, cursor_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic               done_r, done_nxt;

  logic [GS_W-1:0]    w_cl, h_cl;
  logic [RB_W-1:0]    row_bytes;
  logic [PA_W-1:0]    pix_idx;
  logic [PA_W-1:0]    set_idx;
  logic               glyph_bit;
  logic               last_col, last_row;
  logic [CUR_W:0]     cur_sum;

  assign w_cl      = clamp_size(cfg.width);
  assign h_cl      = clamp_size(cfg.height);
  assign row_bytes = RB_W'((32'(w_cl) + 7) >> 3);
  assign pix_idx   = row_base_r + PA_W'(c_r);
  assign set_idx   = ymul_r + PA_W'(x_r);
  assign glyph_bit = fo_rdata[c_r[2:0]] && !oob_r;
  assign last_col  = (GS_W'(c_r) + GS_W'(1)) == w_r;
  assign last_row  = (GS_W'(row_r) + GS_W'(1)) == h_r;
  assign cur_sum   = (CUR_W+1)'(cursor_r) + (CUR_W+1)'(w_r);
  assign in_stall  = (state_r != ST_IDLE);

  // sequencer next state and memory requests
  always_comb begin
    state_nxt    = state_r;
    is_set_nxt   = is_set_r;
    in_range_nxt = in_range_r;
    idx_nxt      = idx_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    color_nxt    = color_r;
    fwa_nxt      = fwa_r;
    fwb_nxt      = fwb_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    gbytes_nxt   = gbytes_r;
    fa_nxt       = fa_r;
    oob_nxt      = oob_r;
    c_nxt        = c_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    ymul_nxt     = ymul_r;
    sweep_nxt    = sweep_r;
    cursor_nxt   = cursor_r;
    pix_nxt      = pix_r;
    done_nxt     = done_r;
    fr_req       = '0;
    fo_req       = '0;
    res          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt      = in_char_code - CODE_W'(FIRST_CODE);
          x_nxt        = in_pos_x;
          y_nxt        = in_pos_y;
          color_nxt    = in_pixel_color;
          fwa_nxt      = FONT_AW'(in_font_addr);
          fwb_nxt      = in_font_byte;
          w_nxt        = w_cl;
          h_nxt        = h_cl;
          gbytes_nxt   = GB_W'(row_bytes) * GB_W'(h_cl) + GB_W'(HDR_BYTES);
          pix_nxt      = '0;
          done_nxt     = 1'b1;
          in_range_nxt = (32'(in_pos_x) < FB_COLS) && (32'(in_pos_y) < FB_ROWS);
          is_set_nxt   = (in_func == FN_SET);
          sweep_nxt    = '0;
          unique case (in_func)
            FN_DRAW:  state_nxt = ST_DSETUP;
            FN_SET:   state_nxt = ST_PMUL;
            FN_READ:  state_nxt = ST_PMUL;
            FN_CLEAR: state_nxt = ST_CLR;
            FN_FONT: begin
              in_range_nxt = (32'(in_font_addr) < FONT_BYTES);
              state_nxt    = ST_FWR;
            end
            default: begin
              done_nxt  = 1'b0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // glyph start address and first row position
      ST_DSETUP: begin
        fa_nxt       = FA_W'(idx_r) * FA_W'(gbytes_r) + FA_W'(HDR_BYTES);
        row_base_nxt = PA_W'(cursor_r);
        c_nxt        = '0;
        row_nxt      = '0;
        if (w_r == '0 || h_r == '0) state_nxt = ST_DEND;
        else                        state_nxt = ST_DFETCH;
      end

      // fetch one font byte; bytes past the store read as blank
      ST_DFETCH: begin
        fo_req.re   = 1'b1;
        fo_req.addr = FONT_AW'(fa_r);
        oob_nxt     = (32'(fa_r) >= FONT_BYTES);
        state_nxt   = ST_DPAINT;
      end

      // one glyph pixel per cycle, paused for the fetch of each font byte
      ST_DPAINT: begin
        if (glyph_bit && (32'(pix_idx) < PIX_TOTAL)) begin
          fr_req.we    = 1'b1;
          fr_req.addr  = FB_AW'(pix_idx);
          fr_req.wdata = cfg.fore;
        end
        if (last_col) begin
          c_nxt        = '0;
          fa_nxt       = fa_r + FA_W'(1);
          row_base_nxt = row_base_r + PA_W'(FB_COLS);
          row_nxt      = row_r + GC_W'(1);
          if (last_row) state_nxt = ST_DEND;
          else          state_nxt = ST_DFETCH;
        end else if (c_r[2:0] == 3'd7) begin
          c_nxt     = c_r + GC_W'(1);
          fa_nxt    = fa_r + FA_W'(1);
          state_nxt = ST_DFETCH;
        end else begin
          c_nxt = c_r + GC_W'(1);
        end
      end

      // saturating cursor advance
      ST_DEND: begin
        if (32'(cur_sum) > CUR_MAX) cursor_nxt = CUR_W'(CUR_MAX);
        else                        cursor_nxt = CUR_W'(cur_sum);
        state_nxt = ST_DONE;
      end

      // row offset for set and read
      ST_PMUL: begin
        ymul_nxt = PA_W'(y_r) * PA_W'(FB_COLS);
        if (!in_range_r)   state_nxt = ST_DONE;
        else if (is_set_r) state_nxt = ST_PWR;
        else               state_nxt = ST_PRD;
      end

      ST_PWR: begin
        fr_req.we    = 1'b1;
        fr_req.addr  = FB_AW'(set_idx);
        fr_req.wdata = color_r;
        state_nxt    = ST_DONE;
      end

      ST_PRD: begin
        fr_req.re   = 1'b1;
        fr_req.addr = FB_AW'(set_idx);
        state_nxt   = ST_PRDW;
      end

      ST_PRDW: begin
        pix_nxt   = fr_rdata;
        state_nxt = ST_DONE;
      end

      // clear sweep, one pixel per cycle
      ST_CLR: begin
        fr_req.we    = 1'b1;
        fr_req.addr  = sweep_r;
        fr_req.wdata = color_r;
        sweep_nxt    = sweep_r + FB_AW'(1);
        if (32'(sweep_r) == PIX_TOTAL - 1) state_nxt = ST_DONE;
      end

      ST_FWR: begin
        fo_req.we    = in_range_r;
        fo_req.addr  = fwa_r;
        fo_req.wdata = fwb_r;
        state_nxt    = ST_DONE;
      end

      // hand the result to the output register
      ST_DONE: begin
        res.valid = 1'b1;
        res.pixel = pix_r;
        res.done  = done_r;
        if (res_take) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
    end
    is_set_r   <= is_set_nxt;
    in_range_r <= in_range_nxt;
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    color_r    <= color_nxt;
    fwa_r      <= fwa_nxt;
    fwb_r      <= fwb_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    gbytes_r   <= gbytes_nxt;
    fa_r       <= fa_nxt;
    oob_r      <= oob_nxt;
    c_r        <= c_nxt;
    row_r      <= row_nxt;
    row_base_r <= row_base_nxt;
    ymul_r     <= ymul_nxt;
    sweep_r    <= sweep_nxt;
    pix_r      <= pix_nxt;
    done_r     <= done_nxt;
  end

endmodule

// ===== src/glyph_framebuffer_writer.sv =====
// Glyph frame buffer writer. One operation is worked on at a time; the input stalls from
// acceptance until its result beat is loaded into the output register, which frees the
// input while that beat waits. All pixel traffic goes through the single frame store
// port (one access per cycle) and glyph bits through the font store port: a draw paints
// each glyph pixel in turn with one font fetch per glyph byte, a clear is a full sweep
// of the frame store, and a set or read of a position off the buffer touches no store.
// Both stores power up undefined; no clearing pass.
// depends on gfw_pkg, gfw_engine, gfw_frame_mem and gfw_font_mem

module glyph_framebuffer_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gfw_pkg::FUNC_W-1:0]         in_func,
  input  logic [gfw_pkg::CODE_W-1:0]         in_char_code,
  input  logic [gfw_pkg::X_W-1:0]            in_pos_x,
  input  logic [gfw_pkg::Y_W-1:0]            in_pos_y,
  input  logic [gfw_pkg::PIX_W-1:0]          in_pixel_color,
  input  logic [gfw_pkg::FADDR_W-1:0]        in_font_addr,
  input  logic [gfw_pkg::FBYTE_W-1:0]        in_font_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gfw_pkg::PIX_W-1:0]          out_read_pixel,
  output logic                               out_done_res,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gfw_pkg::PADDR_W-1:0]        paddr,
  input  logic [gfw_pkg::CFG_DW-1:0]         pwdata,
  output logic [gfw_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);
  import gfw_pkg::*;

  glyph_cfg_t        cfg_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;
  frame_req_t        fr_req;
  font_req_t         fo_req;
  logic [PIX_W-1:0]  fr_rdata;
  logic [FBYTE_W-1:0] fo_rdata;
  result_t           res;
  logic              res_take;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_done_r;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fore   <= 16'hFFFF;
      cfg_r.width  <= SIZE_W'(12);
      cfg_r.height <= SIZE_W'(12);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FORE:   cfg_r.fore   <= pwdata[PIX_W-1:0];
        REG_WIDTH:  cfg_r.width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: cfg_r.height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_FORE:   prdata = CFG_DW'(cfg_r.fore);
      REG_WIDTH:  prdata = CFG_DW'(cfg_r.width);
      REG_HEIGHT: prdata = CFG_DW'(cfg_r.height);
      default:    prdata = '0;
    endcase
  end

  gfw_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_color (in_pixel_color),
    .in_font_addr   (in_font_addr),
    .in_font_byte   (in_font_byte),
    .cfg            (cfg_r),
    .fr_req         (fr_req),
    .fr_rdata       (fr_rdata),
    .fo_req         (fo_req),
    .fo_rdata       (fo_rdata),
    .res            (res),
    .res_take       (res_take)
  );

  gfw_frame_mem u_frame_mem (
    .clk   (clk),
    .req   (fr_req),
    .rdata (fr_rdata)
  );

  gfw_font_mem u_font_mem (
    .clk   (clk),
    .req   (fo_req),
    .rdata (fo_rdata)
  );

  // output register, free when empty or being taken
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
    end
    if (res_take && res.valid) begin
      out_pixel_r <= res.pixel;
      out_done_r  <= res.done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_pixel = out_pixel_r;
  assign out_done_res   = out_done_r;

  // frame writes never land past the end of the buffer
  a_frame_addr: assert property (@(posedge clk) disable iff (!rst_n)
    fr_req.we |-> (32'(fr_req.addr) < PIX_TOTAL))
    else $error("frame write beyond buffer");

  // an accepted beat keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // font store is never read and written in the same cycle
  a_font_port: assert property (@(posedge clk) disable iff (!rst_n)
    fo_req.we |-> !fo_req.re)
    else $error("font store double access");

  // a result is only taken while the previous beat is out of the way or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_pixel_r) && $stable(out_done_r))
    else $error("pending result overwritten");

endmodule
